>>> hw/rtl/rdwr_pkg.sv
// Package for the random draw without replacement block.
// Holds shared constants, status and function codes and the cell control struct.
// No dependencies.
package rdwr_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int RAND_W    = 32;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int GRP_SZ    = 32;

  typedef enum logic [ST_W-1:0] {
    ST_DRAWN    = 2'd0,
    ST_REJECTED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_REFILLED = 2'd3
  } status_t;

  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_REFILL = 1'b1;

  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  typedef struct packed {
    logic refill;
    logic take;
  } cell_ctl_t;

endpackage

>>> hw/rtl/random_draw_without_replacement.sv
// Random draw without replacement: top level with the cell chain and control.
// Depends on rdwr_pkg and rdwr_cell.
// A word is accepted only in S_IDLE; the group select of the picked cell is then registered,
// and in S_SEL the final select and the add of range_low load the result into the output
// register once it is free, so no new word is taken until the last result is loaded.
// Reset empties the pool and sets range_low to 0 and range_high to 1023; offsets load on refill.
module random_draw_without_replacement import rdwr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int OFF_W   = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1),
  localparam int DATA_W  = VAL_W + ST_W + CNT_W,
  localparam int TDATA_W = ((DATA_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [RAND_W-1:0]  in_tdata,   // random_word
  input  logic               in_tuser,   // func
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // value, status, left_count, zero pad
  input  logic               cfg_wr_en,
  input  logic               cfg_addr,
  input  logic [VAL_W-1:0]   cfg_wr_data
);

  localparam int NGRP = (DEPTH + GRP_SZ - 1) / GRP_SZ;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEL  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [VAL_W-1:0]   low_r, high_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  status_t            st_r, st_nxt;
  logic               out_valid_r;
  logic [TDATA_W-1:0] out_data_r;

  logic               accept;
  logic               load_out;
  cell_ctl_t          ctl;
  logic [CNT_W-1:0]   cand;
  logic [5:0]         nbits;
  logic [CNT_W-1:0]   cnt_m1;
  logic [VAL_W:0]     diff;
  logic [CNT_W-1:0]   refill_cnt;

  logic [OFF_W-1:0]   cell_off [DEPTH];
  logic [OFF_W-1:0]   cell_hit [DEPTH];
  logic [OFF_W-1:0]   grp_or   [NGRP];
  logic [OFF_W-1:0]   grp_r    [NGRP];
  logic [OFF_W-1:0]   pick;
  logic [VAL_W-1:0]   value;

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;
  assign load_out  = !out_valid_r || out_tready;

  always_comb begin
    cnt_m1 = cnt_r - CNT_W'(1);
    nbits  = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (cnt_m1[b]) begin
        nbits = 6'(b + 1);
      end
    end
    if (nbits == '0) begin
      cand = '0;
    end else begin
      cand = CNT_W'(in_tdata >> (6'(RAND_W) - nbits));
    end
  end

  always_comb begin
    diff = {high_r[VAL_W-1], high_r} - {low_r[VAL_W-1], low_r};
    if (diff[VAL_W]) begin
      refill_cnt = '0;
    end else if (diff >= (VAL_W+1)'(DEPTH - 1)) begin
      refill_cnt = CNT_W'(DEPTH);
    end else begin
      refill_cnt = CNT_W'(diff) + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    st_nxt     = st_r;
    ctl.refill = 1'b0;
    ctl.take   = 1'b0;
    if (accept) begin
      if (in_tuser == FUNC_REFILL) begin
        ctl.refill = 1'b1;
        cnt_nxt    = refill_cnt;
        st_nxt     = ST_REFILLED;
      end else if (cnt_r == '0) begin
        st_nxt = ST_EMPTY;
      end else if (cand >= cnt_r) begin
        st_nxt = ST_REJECTED;
      end else begin
        ctl.take = 1'b1;
        cnt_nxt  = cnt_m1;
        st_nxt   = ST_DRAWN;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [OFF_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_off[i+1];
    end
    rdwr_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .cand    (cand),
      .nbr_off (nbr),
      .off     (cell_off[i]),
      .hit_off (cell_hit[i])
    );
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP_SZ; k++) begin
        if (g * GRP_SZ + k < DEPTH) begin
          grp_or[g] = grp_or[g] | cell_hit[g*GRP_SZ+k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (accept) begin
        grp_r[g] <= grp_or[g];
      end
    end
  end

  always_comb begin
    pick = '0;
    for (int g = 0; g < NGRP; g++) begin
      pick = pick | grp_r[g];
    end
    value = (st_r == ST_DRAWN) ? low_r + VAL_W'(pick) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      st_r        <= ST_EMPTY;
      out_valid_r <= 1'b0;
      low_r       <= '0;
      high_r      <= VAL_W'(1023);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      st_r    <= st_nxt;
      if (state_r == S_SEL && load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_RANGE_LOW:  low_r  <= cfg_wr_data;
          REG_RANGE_HIGH: high_r <= cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SEL && load_out) begin
      out_data_r <= TDATA_W'({cnt_r, st_r, value});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> hw/rtl/rdwr_cell.sv
// One pool cell: holds a single offset and shifts from its upper neighbor.
// Depends on rdwr_pkg for the cell control struct.
module rdwr_cell import rdwr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int OFF_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CNT_W-1:0] cand,
  input  logic [OFF_W-1:0] nbr_off,
  output logic [OFF_W-1:0] off,
  output logic [OFF_W-1:0] hit_off
);

  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] off_nxt;
  logic             at_or_above;

  assign at_or_above = cand <= CNT_W'(IDX);

  always_comb begin
    off_nxt = off_r;
    if (ctl.refill) begin
      off_nxt = OFF_W'(IDX);
    end else if (ctl.take && at_or_above) begin
      off_nxt = nbr_off;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
  end

  assign off     = off_r;
  assign hit_off = (cand == CNT_W'(IDX)) ? off_r : '0;

endmodule

>>> bench/tb_random_draw_without_replacement.sv
// Testbench for random_draw_without_replacement: a directed table and then random phases.
// Results come from a pool model or typed table rows; checked on the output stream.
// Depends on rdwr_pkg and the random_draw_without_replacement RTL.
module tb_random_draw_without_replacement;
  timeunit 1ns;
  timeprecision 1ps;
  import rdwr_pkg::*;

  localparam int OFF_W        = $clog2(DEPTH_DEF);
  localparam int CNT_W        = $clog2(DEPTH_DEF + 1);
  localparam int OUT_W        = ((VAL_W + ST_W + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PLAN_ROWS    = 26;
  localparam logic [31:0] EDGE_VALS [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic [CNT_W-1:0] left;
  } draw_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             func;
    logic [31:0]      word;
    logic [31:0]      lo;
    logic [31:0]      hi;
    logic             typed;
    logic [31:0]      want_value;
    status_t          want_status;
    logic [CNT_W-1:0] want_left;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [RAND_W-1:0] in_tdata = '0;
  logic              in_tuser = FUNC_DRAW;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_addr = REG_RANGE_LOW;
  logic [VAL_W-1:0]  cfg_wr_data = '0;

  logic signed [VAL_W-1:0] range_lo = '0;
  logic signed [VAL_W-1:0] range_hi = 32'sd1023;
  logic [OFF_W-1:0]        pool_ofs [DEPTH_DEF];
  int unsigned             pool_cnt = 0;

  draw_res_t pending_draws [$];
  int        mismatches = 0;
  int        cycle_cnt = 0;
  int        hold_requests = 0;
  bit        tx_steady = 1'b0;
  bit        rx_steady = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM, FUNC_DRAW,   32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_EMPTY, 11'd0},
    '{ROW_ITEM, FUNC_DRAW,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0, ST_EMPTY, 11'd0},
    '{ROW_ITEM, FUNC_REFILL, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0, ST_REFILLED, 11'd1024},
    '{ROW_ITEM, FUNC_DRAW,   32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_DRAWN, 11'd1023},
    '{ROW_ITEM, FUNC_DRAW,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0, ST_REJECTED, 11'd1023},
    '{ROW_ITEM, FUNC_DRAW,   32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_CFG,  FUNC_DRAW,   32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_DRAW,   32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_REFILL, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_REFILLED, 11'd1},
    '{ROW_ITEM, FUNC_DRAW,   32'hA5A5_A5A5, 32'h0, 32'h0, 1'b1, 32'h7FFF_FFFF, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_DRAW,   32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_EMPTY, 11'd0},
    '{ROW_CFG,  FUNC_DRAW,   32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_REFILL, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_REFILLED, 11'd1024},
    '{ROW_ITEM, FUNC_DRAW,   32'h5A5A_5A5A, 32'h0, 32'h0, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_CFG,  FUNC_DRAW,   32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_REFILL, 32'h1234_5678, 32'h0, 32'h0, 1'b1, 32'h0, ST_REFILLED, 11'd1},
    '{ROW_ITEM, FUNC_DRAW,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h8000_0000, ST_DRAWN, 11'd0},
    '{ROW_CFG,  FUNC_DRAW,   32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_REFILL, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_REFILLED, 11'd0},
    '{ROW_ITEM, FUNC_DRAW,   32'h1234_5678, 32'h0, 32'h0, 1'b1, 32'h0, ST_EMPTY, 11'd0},
    '{ROW_CFG,  FUNC_DRAW,   32'h0, 32'd10, 32'd12, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_REFILL, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_REFILLED, 11'd3},
    '{ROW_ITEM, FUNC_DRAW,   32'hC000_0000, 32'h0, 32'h0, 1'b1, 32'h0, ST_REJECTED, 11'd3},
    '{ROW_ITEM, FUNC_DRAW,   32'h8000_0000, 32'h0, 32'h0, 1'b1, 32'd12, ST_DRAWN, 11'd2},
    '{ROW_ITEM, FUNC_DRAW,   32'h4000_0000, 32'h0, 32'h0, 1'b0, 32'h0, ST_DRAWN, 11'd0},
    '{ROW_ITEM, FUNC_DRAW,   32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0, 32'h0, ST_DRAWN, 11'd0}
  };

  random_draw_without_replacement uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic draw_res_t apply_to_pool(input logic func, input logic [31:0] word);
    draw_res_t   r;
    longint      lo, hi, size;
    int          n, i;
    int unsigned cand;
    logic [OFF_W-1:0] ofs;
    r.value = '0;
    if (func == FUNC_REFILL) begin
      lo = range_lo;
      hi = range_hi;
      size = (hi < lo) ? 0 : hi - lo + 1;
      if (size > longint'(DEPTH_DEF)) size = longint'(DEPTH_DEF);
      pool_cnt = 32'(size);
      for (i = 0; i < pool_cnt; i++) pool_ofs[i] = OFF_W'(i);
      r.status = ST_REFILLED;
    end else if (pool_cnt == 0) begin
      r.status = ST_EMPTY;
    end else begin
      n = 0;
      while ((1 << n) < pool_cnt) n++;
      cand = (n == 0) ? 0 : int'(word >> (32 - n));
      if (cand >= pool_cnt) begin
        r.status = ST_REJECTED;
      end else begin
        ofs = pool_ofs[cand];
        for (i = cand; i + 1 < pool_cnt; i++) pool_ofs[i] = pool_ofs[i + 1];
        pool_cnt--;
        r.value = range_lo + VAL_W'(ofs);
        r.status = ST_DRAWN;
      end
    end
    r.left = CNT_W'(pool_cnt);
    return r;
  endfunction

  task automatic send_item(input logic func, input logic [31:0] word, input logic typed,
                           input draw_res_t typed_res);
    int        gap;
    draw_res_t pred;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= word;
    do @(posedge clk); while (!in_tready);
    pred = apply_to_pool(func, word);
    pending_draws.push_back(typed ? typed_res : pred);
  endtask

  // Every result is out and the pipeline has settled.
  task automatic drain_results();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_range(input logic do_lo, input logic [31:0] lo,
                            input logic do_hi, input logic [31:0] hi);
    drain_results();
    if (do_lo) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr <= REG_RANGE_LOW;
      cfg_wr_data <= lo;
      range_lo = lo;
    end
    if (do_hi) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr <= REG_RANGE_HIGH;
      cfg_wr_data <= hi;
      range_hi = hi;
    end
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int hold_seen, hold_left, stall_left;
    hold_seen = 0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_out
    draw_res_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[VAL_W-1:0];
      got.status = status_t'(out_tdata[VAL_W +: ST_W]);
      got.left = out_tdata[VAL_W + ST_W +: CNT_W];
      if (pending_draws.size() == 0) begin
        $display("%0t: word with nothing expected, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_draws.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: value expected %h got %h", $time, want.value, got.value);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.left !== want.left) begin
          $display("%0t: left_count expected %0d got %0d", $time, want.left, got.left);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          r, k, ndraws, mode, rand_cnt;
    logic [31:0] lo, hi;
    bit          hold_done;
    draw_res_t   typed;
    hold_done = 1'b0;
    rand_cnt = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        load_range(1'b1, plan[r].lo, 1'b1, plan[r].hi);
      end else begin
        typed = '{plan[r].want_value, plan[r].want_status, plan[r].want_left};
        send_item(plan[r].func, plan[r].word, plan[r].typed, typed);
      end
    end

    while (rand_cnt < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if (pool_cnt != 0 && $urandom_range(0, 7) == 0) begin
        // Move range_low under a live pool; no refill is sent with it.
        load_range(1'b1, $urandom, 1'b0, 32'h0);
      end else begin
        mode = $urandom_range(0, 99);
        lo = $urandom;
        if (mode < 55) begin
          hi = lo + $urandom_range(0, 40);
        end else if (mode < 65) begin
          hi = lo - $urandom_range(1, 1000);
        end else if (mode < 75) begin
          hi = lo + $urandom_range(1024, 32'h7FFF_FFFF);
        end else if (mode < 85) begin
          lo = EDGE_VALS[$urandom_range(0, 3)];
          hi = EDGE_VALS[$urandom_range(0, 3)];
        end else begin
          lo = $urandom_range(0, 1000) - 500;
          hi = lo + $urandom_range(900, 1100);
        end
        load_range(1'b1, lo, 1'b1, hi);
        send_item(FUNC_REFILL, $urandom, 1'b0, typed);
        rand_cnt++;
      end
      ndraws = (pool_cnt <= 40) ? 3 * pool_cnt + $urandom_range(1, 4) : $urandom_range(20, 60);
      if (!hold_done && rand_cnt >= 400) begin
        // Keep offering words through the long receiver hold so the input stalls.
        hold_done = 1'b1;
        tx_steady = 1'b1;
        hold_requests++;
        ndraws = ndraws + 8;
      end
      for (k = 0; k < ndraws && rand_cnt < RANDOM_ITEMS; k++) begin
        if ($urandom_range(0, 29) == 0) send_item(FUNC_REFILL, $urandom, 1'b0, typed);
        else send_item(FUNC_DRAW, $urandom, 1'b0, typed);
        rand_cnt++;
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
